/* sv/tlbft_pkg.sv */
// shared constants for the fifo tlb translator
package tlbft_pkg;

   // fixed field widths
   localparam int VA_W    = 32;
   localparam int FRAME_W = 20;
   localparam int COUNT_W = 32;

   // default geometry
   localparam int DEF_TLB_ENTRIES = 8;
   localparam int DEF_OFFSET_BITS = 12;

endpackage

/* sv/fifo_tlb_translator.sv */
// fully associative tlb with fifo replacement and saturating counters
// a request is captured in the input register, looked up, and its result is held in the result register
// throughput: one request per cycle while reset is low, set by the parallel tag compare
// busy is high only while reset is asserted; the receiver cannot stall
// reset clears the valid bits, both counters and the stage strobes
// tag and frame entries are not cleared and are read only when valid
module fifo_tlb_translator
   import tlbft_pkg::*;
#(
   parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
   parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [VA_W-1:0]    req_virt_addr,
   input  logic               req_table_present,
   input  logic               req_entry_valid,
   input  logic [FRAME_W-1:0] req_entry_frame,
   output logic               rsp_valid,
   output logic [VA_W-1:0]    rsp_phys_addr,
   output logic               rsp_fault,
   output logic               rsp_tlb_hit,
   output logic [COUNT_W-1:0] rsp_hit_count,
   output logic [COUNT_W-1:0] rsp_access_count
);

   localparam int PAGE_W = VA_W - OFFSET_BITS;
   localparam int IDX_W  = $clog2(TLB_ENTRIES);
   localparam int WIDE_W = FRAME_W + OFFSET_BITS;

   // input register
   logic               req_valid_ff;
   logic [VA_W-1:0]    va_ff;
   logic               present_ff;
   logic               ent_ok_ff;
   logic [FRAME_W-1:0] walk_frame_ff;

   // tlb state
   logic [PAGE_W-1:0]      tag_ff   [TLB_ENTRIES];
   logic [PAGE_W-1:0]      tag_in   [TLB_ENTRIES];
   logic [FRAME_W-1:0]     frame_ff [TLB_ENTRIES];
   logic [FRAME_W-1:0]     frame_in [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] valid_ff;
   logic [TLB_ENTRIES-1:0] valid_in;
   logic [COUNT_W-1:0]     hits_ff;
   logic [COUNT_W-1:0]     hits_in;
   logic [COUNT_W-1:0]     accesses_ff;
   logic [COUNT_W-1:0]     accesses_in;

   // lookup signals
   logic [PAGE_W-1:0]      page;
   logic [OFFSET_BITS-1:0] offset;
   logic                   hit;
   logic [FRAME_W-1:0]     hit_frame;
   logic                   walk_fault;
   logic                   do_install;
   logic                   free_found;
   logic [IDX_W-1:0]       free_idx;
   logic [FRAME_W-1:0]     use_frame;
   logic [WIDE_W-1:0]      wide_addr;
   logic [63:0]            wide_ext;
   logic [VA_W-1:0]        phys_in;

   // result register
   logic               rsp_valid_ff;
   logic [VA_W-1:0]    phys_ff;
   logic               fault_ff;
   logic               tlb_hit_ff;

   assign busy = reset;

   // capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
      va_ff         <= req_virt_addr;
      present_ff    <= req_table_present;
      ent_ok_ff     <= req_entry_valid;
      walk_frame_ff <= req_entry_frame;
   end

   assign page   = va_ff[VA_W-1:OFFSET_BITS];
   assign offset = va_ff[OFFSET_BITS-1:0];

   // parallel tag compare, first match wins
   always_comb begin
      hit       = 1'b0;
      hit_frame = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (!hit && valid_ff[i] && tag_ff[i] == page) begin
            hit       = 1'b1;
            hit_frame = frame_ff[i];
         end
      end
   end

   // first empty slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (!free_found && !valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign walk_fault = !hit && (!present_ff || !ent_ok_ff);
   assign do_install = req_valid_ff && !hit && !walk_fault;
   assign use_frame  = hit ? hit_frame : walk_frame_ff;

   // physical address, bits above the address width dropped
   assign wide_addr = {use_frame, offset};
   assign wide_ext  = 64'(wide_addr);
   assign phys_in   = walk_fault ? '0 : wide_ext[VA_W-1:0];

   // install into an empty slot or shift out the oldest entry
   always_comb begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         tag_in[i]   = tag_ff[i];
         frame_in[i] = frame_ff[i];
      end
      valid_in = valid_ff;
      if (do_install) begin
         if (free_found) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
               if (free_idx == IDX_W'(i)) begin
                  tag_in[i]   = page;
                  frame_in[i] = walk_frame_ff;
                  valid_in[i] = 1'b1;
               end
            end
         end else begin
            for (int i = 0; i < TLB_ENTRIES - 1; i++) begin
               tag_in[i]   = tag_ff[i+1];
               frame_in[i] = frame_ff[i+1];
               valid_in[i] = valid_ff[i+1];
            end
            tag_in[TLB_ENTRIES-1]   = page;
            frame_in[TLB_ENTRIES-1] = walk_frame_ff;
            valid_in[TLB_ENTRIES-1] = 1'b1;
         end
      end
   end

   // saturating counters
   always_comb begin
      accesses_in = accesses_ff;
      hits_in     = hits_ff;
      if (req_valid_ff) begin
         if (accesses_ff != '1) begin
            accesses_in = accesses_ff + COUNT_W'(1);
         end
         if (hit && hits_ff != '1) begin
            hits_in = hits_ff + COUNT_W'(1);
         end
      end
   end

   // tlb entries, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         tag_ff[i]   <= tag_in[i];
         frame_ff[i] <= frame_in[i];
      end
   end

   // control state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         hits_ff      <= '0;
         accesses_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         hits_ff      <= hits_in;
         accesses_ff  <= accesses_in;
         rsp_valid_ff <= req_valid_ff;
      end
      phys_ff    <= phys_in;
      fault_ff   <= walk_fault;
      tlb_hit_ff <= hit;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phys_addr    = phys_ff;
   assign rsp_fault        = fault_ff;
   assign rsp_tlb_hit      = tlb_hit_ff;
   assign rsp_hit_count    = hits_ff;
   assign rsp_access_count = accesses_ff;

endmodule

/* sv/fifo_tlb_translator_checker.sv */
// port level checks for the fifo tlb translator, bound into the translator module
module fifo_tlb_translator_checker
   import tlbft_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [VA_W-1:0]    rsp_phys_addr,
   input logic               rsp_fault,
   input logic               rsp_tlb_hit,
   input logic [COUNT_W-1:0] rsp_hit_count,
   input logic [COUNT_W-1:0] rsp_access_count
);

   // every result comes from an accepted request, passed through the input and result registers
   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a matching request");

   // a fault gives a zero address and never a hit
   a_fault_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_phys_addr == '0 && !rsp_tlb_hit)
      else $error("fault result with address or hit set");

   // hits never outnumber accesses, and a result counts itself
   a_counts_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_count <= rsp_access_count && rsp_access_count != '0)
      else $error("counter relation broken");

   // the access count moves forward across back to back results
   a_access_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) && $past(rsp_access_count) != '1
         |-> rsp_access_count == $past(rsp_access_count) + COUNT_W'(1))
      else $error("access count did not advance");

endmodule

bind fifo_tlb_translator fifo_tlb_translator_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_phys_addr    (rsp_phys_addr),
   .rsp_fault        (rsp_fault),
   .rsp_tlb_hit      (rsp_tlb_hit),
   .rsp_hit_count    (rsp_hit_count),
   .rsp_access_count (rsp_access_count)
);

/* dv/testbench.sv */
// self-checking testbench for the fifo tlb translator with a built-in translation predictor
`timescale 1ns / 1ps

module testbench;
   import tlbft_pkg::*;

   localparam int ENTRIES    = DEF_TLB_ENTRIES;
   localparam int OFS_W      = DEF_OFFSET_BITS;
   localparam int PAGE_W     = VA_W - OFS_W;
   localparam int N_RANDOM   = 1880;
   localparam int POOL_SIZE  = 12;
   localparam int CYCLE_CAP  = 400000;
   localparam int PRINT_CAP  = 40;
   localparam int DRAIN_WAIT = 8;

   typedef struct {
      bit [VA_W-1:0]    va;
      bit               present;
      bit               ent_ok;
      bit [FRAME_W-1:0] frame;
   } xlate_req_type;

   typedef struct {
      bit [VA_W-1:0]    phys;
      bit               fault;
      bit               hit;
      bit [COUNT_W-1:0] hits;
      bit [COUNT_W-1:0] accesses;
   } xlate_rsp_type;

   // block ports
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [VA_W-1:0]    req_virt_addr = '0;
   logic               req_table_present = 1'b0;
   logic               req_entry_valid = 1'b0;
   logic [FRAME_W-1:0] req_entry_frame = '0;
   logic               rsp_valid;
   logic [VA_W-1:0]    rsp_phys_addr;
   logic               rsp_fault;
   logic               rsp_tlb_hit;
   logic [COUNT_W-1:0] rsp_hit_count;
   logic [COUNT_W-1:0] rsp_access_count;

   // predictor copy of the tlb and counters
   bit [PAGE_W-1:0]  tlb_tag   [ENTRIES];
   bit [FRAME_W-1:0] tlb_frame [ENTRIES];
   bit               tlb_valid [ENTRIES];
   bit [COUNT_W-1:0] hits_total;
   bit [COUNT_W-1:0] accesses_total;

   // request and result bookkeeping
   xlate_req_type pending_reqs[$];
   xlate_rsp_type expected_xlate[$];
   xlate_req_type cur_req;
   xlate_rsp_type got_rsp;
   int         n_queued;
   int         n_sent;
   int         n_results;
   int         n_errors;
   int         n_hits_seen;
   int         n_faults_seen;
   int         n_evictions;
   int         gap_left;
   int         burst_left;
   int         cycle_count;

   fifo_tlb_translator #(
      .TLB_ENTRIES(ENTRIES),
      .OFFSET_BITS(OFS_W)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_virt_addr    (req_virt_addr),
      .req_table_present(req_table_present),
      .req_entry_valid  (req_entry_valid),
      .req_entry_frame  (req_entry_frame),
      .rsp_valid        (rsp_valid),
      .rsp_phys_addr    (rsp_phys_addr),
      .rsp_fault        (rsp_fault),
      .rsp_tlb_hit      (rsp_tlb_hit),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_access_count (rsp_access_count)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit [COUNT_W-1:0] sat_bump(bit [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // translate one request and update the tlb copy the way the block should
   function automatic xlate_rsp_type predict_translation(xlate_req_type rq);
      bit [PAGE_W-1:0]  page;
      bit [OFS_W-1:0]   ofs;
      bit [FRAME_W-1:0] frm;
      bit [63:0]        wide;
      bit               found;
      int               slot;
      xlate_rsp_type    rs;
      page  = rq.va[VA_W-1:OFS_W];
      ofs   = rq.va[OFS_W-1:0];
      frm   = '0;
      found = 1'b0;
      slot  = -1;
      rs    = '{default: '0};
      accesses_total = sat_bump(accesses_total);
      // parallel tag compare, lowest slot wins
      for (int i = 0; i < ENTRIES; i++) begin
         if (!found && tlb_valid[i] && tlb_tag[i] == page) begin
            found = 1'b1;
            frm   = tlb_frame[i];
         end
      end
      if (found) begin
         hits_total = sat_bump(hits_total);
         n_hits_seen++;
      end else if (!rq.present || !rq.ent_ok) begin
         rs.fault = 1'b1;
         n_faults_seen++;
      end else begin
         frm = rq.frame;
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !tlb_valid[i]) slot = i;
         end
         // full table: shift toward slot 0 and drop the oldest
         if (slot < 0) begin
            for (int i = 0; i < ENTRIES - 1; i++) begin
               tlb_tag[i]   = tlb_tag[i + 1];
               tlb_frame[i] = tlb_frame[i + 1];
               tlb_valid[i] = tlb_valid[i + 1];
            end
            slot = ENTRIES - 1;
            n_evictions++;
         end
         tlb_tag[slot]   = page;
         tlb_frame[slot] = frm;
         tlb_valid[slot] = 1'b1;
      end
      if (!rs.fault) begin
         wide    = (64'(frm) << OFS_W) | 64'(ofs);
         rs.phys = wide[VA_W-1:0];
      end
      rs.hit      = found;
      rs.hits     = hits_total;
      rs.accesses = accesses_total;
      return rs;
   endfunction

   task automatic report_error(string msg);
      n_errors++;
      if (n_errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic add_req(bit [VA_W-1:0] va, bit present, bit ent_ok, bit [FRAME_W-1:0] frame);
      xlate_req_type rq;
      rq.va      = va;
      rq.present = present;
      rq.ent_ok  = ent_ok;
      rq.frame   = frame;
      pending_reqs.push_back(rq);
      n_queued++;
   endtask

   // idle length between requests: mostly none, some short, a few long, with gapless bursts
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(30, 80);
         return 0;
      end
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // driver: hold a request until accepted, then move to the next after its gap
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            expected_xlate.push_back(predict_translation(cur_req));
            n_sent++;
            gap_left = pick_gap();
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req_virt_addr     <= cur_req.va;
               req_table_present <= cur_req.present;
               req_entry_valid   <= cur_req.ent_ok;
               req_entry_frame   <= cur_req.frame;
               start             <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: compare every strobed result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         n_results++;
         if (expected_xlate.size() == 0) begin
            report_error($sformatf("result with no request pending, phys_addr %h", rsp_phys_addr));
         end else begin
            got_rsp = expected_xlate.pop_front();
            if (rsp_phys_addr !== got_rsp.phys)
               report_error($sformatf("phys_addr got %h want %h", rsp_phys_addr, got_rsp.phys));
            if (rsp_fault !== got_rsp.fault)
               report_error($sformatf("fault got %b want %b", rsp_fault, got_rsp.fault));
            if (rsp_tlb_hit !== got_rsp.hit)
               report_error($sformatf("tlb_hit got %b want %b", rsp_tlb_hit, got_rsp.hit));
            if (rsp_hit_count !== got_rsp.hits)
               report_error($sformatf("hit_count got %0d want %0d", rsp_hit_count, got_rsp.hits));
            if (rsp_access_count !== got_rsp.accesses)
               report_error($sformatf("access_count got %0d want %0d",
                                      rsp_access_count, got_rsp.accesses));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d requests still expected",
                  cycle_count, expected_xlate.size());
         $display("testbench failed");
         $finish;
      end
   end

   // stimulus, reset and end of run
   initial begin
      bit [PAGE_W-1:0] page_pool [POOL_SIZE];
      bit [PAGE_W-1:0] page;
      for (int i = 0; i < ENTRIES; i++) begin
         tlb_tag[i]   = '0;
         tlb_frame[i] = '0;
         tlb_valid[i] = 1'b0;
      end
      hits_total     = '0;
      accesses_total = '0;

      // walk faults on an empty table, each way
      add_req(32'h0000_0000, 1'b0, 1'b1, 20'hFFFFF);
      add_req(32'h0000_0FFF, 1'b1, 1'b0, 20'h12345);
      add_req(32'hFFFF_FFFF, 1'b0, 1'b0, 20'h00000);
      // install page 0 with frame 0, then hit it with a faulting walk
      add_req(32'h0000_0000, 1'b1, 1'b1, 20'h00000);
      add_req(32'h0000_0ABC, 1'b0, 1'b0, 20'hFFFFF);
      // top page to top frame, then fill the rest of the table
      add_req(32'hFFFF_FFFF, 1'b1, 1'b1, 20'hFFFFF);
      for (int i = 1; i <= 6; i++)
         add_req({20'(i), 12'h5A5}, 1'b1, 1'b1, 20'(32'hA5A5A * i));
      // full table: a new page evicts the oldest (page 0)
      add_req(32'h1234_5678, 1'b1, 1'b1, 20'h0F0F0);
      add_req(32'h0000_0123, 1'b0, 1'b1, 20'h00000);
      add_req(32'hFFFF_F000, 1'b0, 1'b0, 20'h00000);
      add_req(32'h1234_5FFF, 1'b1, 1'b1, 20'h11111);
      // page 0 back in evicts the top page
      add_req(32'h0000_0800, 1'b1, 1'b1, 20'h80000);
      add_req(32'hFFFF_F001, 1'b1, 1'b1, 20'h7FFFF);

      // random part: a small working set so hits, fills and evictions all happen
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 200 == 0) begin
            for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = PAGE_W'($urandom);
            if (n % 400 == 0) begin
               page_pool[0] = '0;
               page_pool[1] = '1;
            end
         end
         if ($urandom_range(0, 99) < 75) page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
         else page = PAGE_W'($urandom);
         add_req({page, OFS_W'($urandom)}, $urandom_range(0, 9) != 0,
                 $urandom_range(0, 9) != 0, FRAME_W'($urandom));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (n_sent < n_queued) @(posedge clock);
      while (expected_xlate.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d requests translated, %0d results checked, %0d mismatches",
               n_sent, n_results, n_errors);
      $display("tlb hits %0d, walk faults %0d, fifo evictions %0d",
               n_hits_seen, n_faults_seen, n_evictions);
      if (n_errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/tlbft_pkg.sv
sv/fifo_tlb_translator.sv
sv/fifo_tlb_translator_checker.sv
dv/testbench.sv
